// ===== hw/rtl/tcd_pkg.sv =====
// Package for the clap detector: configuration, state and result types,
// register indexes, reset values and the amplitude helper. No dependencies.
package tcd_pkg;

   localparam int SAMPLE_SHIFT = 14;
   localparam int PEAK_W       = 18;
   localparam int TIME_W       = 32;
   localparam int HOLD_W       = 16;
   localparam int COUNT_W      = 4;
   localparam int WORD_W       = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 18;

   localparam logic [PEAK_W-1:0] PEAK_MAX       = '1;
   localparam logic [TIME_W-1:0] SHORT_EVENT_MS = 32'd5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_HOLD_MS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CLAP_MS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPULSE_MIN_AMPL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SEQUENCE_MS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_MS       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAPS_NEEDED      = 3'd6;

   // Reset values of the registers.
   localparam logic [PEAK_W-1:0]  RST_NOISE_THRESHOLD  = 18'd3000;
   localparam logic [HOLD_W-1:0]  RST_SILENCE_HOLD_MS  = 16'd50;
   localparam logic [HOLD_W-1:0]  RST_MAX_CLAP_MS      = 16'd60;
   localparam logic [PEAK_W-1:0]  RST_IMPULSE_MIN_AMPL = 18'd10000;
   localparam logic [HOLD_W-1:0]  RST_MAX_SEQUENCE_MS  = 16'd2000;
   localparam logic [HOLD_W-1:0]  RST_COOLDOWN_MS      = 16'd1500;
   localparam logic [COUNT_W-1:0] RST_CLAPS_NEEDED     = 4'd3;

   typedef struct packed {
      logic [PEAK_W-1:0]  noise_threshold;
      logic [HOLD_W-1:0]  silence_hold_ms;
      logic [HOLD_W-1:0]  max_clap_ms;
      logic [PEAK_W-1:0]  impulse_min_amplitude;
      logic [HOLD_W-1:0]  max_sequence_ms;
      logic [HOLD_W-1:0]  cooldown_ms;
      logic [COUNT_W-1:0] claps_needed;
   } cfg_type;

   // Detector state carried from batch to batch (the running batch peak
   // lives in the top level).
   typedef struct packed {
      logic               event_active;
      logic [TIME_W-1:0]  event_start_ms;
      logic [TIME_W-1:0]  last_loud_ms;
      logic [PEAK_W-1:0]  event_peak;
      logic [COUNT_W-1:0] clap_count;
      logic [TIME_W-1:0]  first_clap_ms;
      logic               light_state;
      logic               cooling;
      logic [TIME_W-1:0]  toggle_ms;
   } state_type;

   typedef struct packed {
      logic               light_on;
      logic               toggled;
      logic               clap_accepted;
      logic [COUNT_W-1:0] claps_so_far;
      logic               batch_skipped;
   } rsp_type;

   // Magnitude of the arithmetically shifted word, saturated to the peak width.
   function automatic logic [PEAK_W-1:0] amplitude_of(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] shifted;
      logic [WORD_W-1:0] mag;
      shifted = WORD_W'($signed(word) >>> SAMPLE_SHIFT);
      mag     = word[WORD_W-1] ? (~shifted + 1'b1) : shifted;
      if (mag > WORD_W'(PEAK_MAX)) begin
         amplitude_of = PEAK_MAX;
      end else begin
         amplitude_of = mag[PEAK_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/tcd_csr.sv =====
// Configuration registers of the clap detector, written through a plain
// write port. Depends on tcd_pkg.
module tcd_csr
   import tcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NOISE_THRESHOLD:  cfg_in.noise_threshold       = csr_wdata[PEAK_W-1:0];
            CSR_SILENCE_HOLD_MS:  cfg_in.silence_hold_ms       = csr_wdata[HOLD_W-1:0];
            CSR_MAX_CLAP_MS:      cfg_in.max_clap_ms           = csr_wdata[HOLD_W-1:0];
            CSR_IMPULSE_MIN_AMPL: cfg_in.impulse_min_amplitude = csr_wdata[PEAK_W-1:0];
            CSR_MAX_SEQUENCE_MS:  cfg_in.max_sequence_ms       = csr_wdata[HOLD_W-1:0];
            CSR_COOLDOWN_MS:      cfg_in.cooldown_ms           = csr_wdata[HOLD_W-1:0];
            CSR_CLAPS_NEEDED:     cfg_in.claps_needed          = csr_wdata[COUNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_threshold       <= RST_NOISE_THRESHOLD;
         cfg_ff.silence_hold_ms       <= RST_SILENCE_HOLD_MS;
         cfg_ff.max_clap_ms           <= RST_MAX_CLAP_MS;
         cfg_ff.impulse_min_amplitude <= RST_IMPULSE_MIN_AMPL;
         cfg_ff.max_sequence_ms       <= RST_MAX_SEQUENCE_MS;
         cfg_ff.cooldown_ms           <= RST_COOLDOWN_MS;
         cfg_ff.claps_needed          <= RST_CLAPS_NEEDED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/tcd_eval.sv =====
// Batch evaluation of the clap detector: cooldown, stale sequence, event
// tracking, clap decision and light toggle. Combinational. Depends on tcd_pkg.
module tcd_eval
   import tcd_pkg::*;
(
   input  cfg_type            cfg,
   input  state_type          state_cur,
   input  logic [PEAK_W-1:0]  peak,
   input  logic [TIME_W-1:0]  now_ms,
   output state_type          state_next,
   output rsp_type            rsp
);

   always_comb begin
      state_type          st;
      logic [TIME_W-1:0]  since_toggle;
      logic [TIME_W-1:0]  since_first;
      logic [TIME_W-1:0]  since_loud;
      logic [TIME_W-1:0]  duration;
      logic [COUNT_W-1:0] need;
      logic               skipped;
      logic               accepted;
      logic               toggled;

      st           = state_cur;
      skipped      = 1'b0;
      accepted     = 1'b0;
      toggled      = 1'b0;
      since_toggle = now_ms - state_cur.toggle_ms;
      since_first  = now_ms - state_cur.first_clap_ms;
      need         = (cfg.claps_needed == '0) ? COUNT_W'(1) : cfg.claps_needed;
      since_loud   = '0;
      duration     = '0;

      if (st.cooling && (since_toggle < TIME_W'(cfg.cooldown_ms))) begin
         skipped = 1'b1;
      end else begin
         st.cooling = 1'b0;
         if ((st.clap_count != '0) && (since_first > TIME_W'(cfg.max_sequence_ms))) begin
            st.clap_count = '0;
         end

         if (peak > cfg.noise_threshold) begin
            if (!st.event_active) begin
               st.event_active   = 1'b1;
               st.event_start_ms = now_ms;
               st.event_peak     = peak;
            end
            st.last_loud_ms = now_ms;
            if (peak > st.event_peak) begin
               st.event_peak = peak;
            end
         end

         since_loud = now_ms - st.last_loud_ms;
         duration   = st.last_loud_ms - st.event_start_ms;
         if (st.event_active && (since_loud > TIME_W'(cfg.silence_hold_ms))) begin
            st.event_active = 1'b0;
            if ((duration >= SHORT_EVENT_MS) && (duration <= TIME_W'(cfg.max_clap_ms))) begin
               accepted = 1'b1;
            end else if ((duration < SHORT_EVENT_MS) &&
                         (st.event_peak > cfg.impulse_min_amplitude)) begin
               accepted = 1'b1;
            end

            if (accepted) begin
               st.clap_count = st.clap_count + 1'b1;
               if (st.clap_count == COUNT_W'(1)) begin
                  st.first_clap_ms = now_ms;
               end
               if (st.clap_count >= need) begin
                  st.light_state = !st.light_state;
                  st.clap_count  = '0;
                  st.cooling     = 1'b1;
                  st.toggle_ms   = now_ms;
                  toggled        = 1'b1;
               end
            end
         end
      end

      state_next        = st;
      rsp.light_on      = st.light_state;
      rsp.toggled       = toggled;
      rsp.clap_accepted = accepted;
      rsp.claps_so_far  = st.clap_count;
      rsp.batch_skipped = skipped;
   end

endmodule

// ===== hw/rtl/triple_clap_detector.sv =====
// Top level of the clap detector: request register, peak tracking, state
// registers and response register. Depends on tcd_pkg, tcd_csr and tcd_eval.
//
// The block takes one microphone request per clock cycle unless it is stalled
// as described below. Each request is captured in an input register; in the
// following cycle its amplitude (the word shifted right arithmetically by 14,
// taken as a magnitude and saturated to 18 bits) updates the running batch
// peak. A request with batch_end set also evaluates the batch against the
// detector state when it leaves the input register and loads exactly one
// response into the output register; requests without batch_end produce no
// response. The output register lets new requests enter while a response waits
// to be taken. The block stops accepting requests only when a batch-end request
// sits in the input register and the previous response has not yet been taken,
// and req_ready then follows rsp_ready in the same cycle. Configuration
// registers are written through the csr_ port at any clock edge with csr_wr_en
// high; writes to an index beyond the seven registers are ignored. Change
// configuration only while no request is in flight.
module triple_clap_detector
   import tcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_sample_word,
   input  logic                  req_batch_end,
   input  logic [TIME_W-1:0]     req_now_ms,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_light_on,
   output logic                  rsp_toggled,
   output logic                  rsp_clap_accepted,
   output logic [COUNT_W-1:0]    rsp_claps_so_far,
   output logic                  rsp_batch_skipped,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   tcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register. Only the valid bit needs a reset.
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff;
   logic              s1_end_ff;
   logic [TIME_W-1:0] s1_now_ff;

   // Running batch peak and the detector state.
   logic [PEAK_W-1:0] batch_peak_ff;
   logic [PEAK_W-1:0] batch_peak_in;
   state_type         state_ff;
   state_type         state_in;

   // Response register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              s1_advance;
   logic              s1_step;
   logic              rsp_load;
   logic              req_take;
   logic [PEAK_W-1:0] amp;
   logic [PEAK_W-1:0] peak;
   state_type         state_eval;
   rsp_type           rsp_eval;

   // A request without batch end never produces a response, so it can always
   // leave the input register. A batch-end request needs room in the output
   // register, which is there when it is empty or being emptied this cycle.
   assign s1_advance = !s1_end_ff || !rsp_valid_ff || rsp_ready;
   assign s1_step    = s1_valid_ff && s1_advance;
   assign rsp_load   = s1_step && s1_end_ff;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

   // The batch peak seen by the evaluation includes the closing sample.
   assign amp  = amplitude_of(s1_word_ff);
   assign peak = (amp > batch_peak_ff) ? amp : batch_peak_ff;

   tcd_eval u_eval (
      .cfg        (cfg),
      .state_cur  (state_ff),
      .peak       (peak),
      .now_ms     (s1_now_ff),
      .state_next (state_eval),
      .rsp        (rsp_eval)
   );

   always_comb begin
      batch_peak_in = batch_peak_ff;
      state_in      = state_ff;
      if (s1_step) begin
         if (s1_end_ff) begin
            batch_peak_in = '0;
            state_in      = state_eval;
         end else begin
            batch_peak_in = peak;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_in       = rsp_eval;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         batch_peak_ff <= '0;
         state_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         batch_peak_ff <= batch_peak_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_sample_word;
         s1_end_ff  <= req_batch_end;
         s1_now_ff  <= req_now_ms;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_light_on      = rsp_ff.light_on;
   assign rsp_toggled       = rsp_ff.toggled;
   assign rsp_clap_accepted = rsp_ff.clap_accepted;
   assign rsp_claps_so_far  = rsp_ff.claps_so_far;
   assign rsp_batch_skipped = rsp_ff.batch_skipped;

endmodule

// ===== hw/rtl/tcd_checker.sv =====
// Port-level checks for the clap detector and the bind that attaches them to
// the top level. Depends on tcd_pkg and triple_clap_detector.
module tcd_checker
   import tcd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_light_on,
   input logic                  rsp_toggled,
   input logic                  rsp_clap_accepted,
   input logic [COUNT_W-1:0]    rsp_claps_so_far,
   input logic                  rsp_batch_skipped
);

   // A stalled response stays valid and keeps all its fields but the skip flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_light_on) &&
      $stable(rsp_toggled) && $stable(rsp_clap_accepted) && $stable(rsp_claps_so_far))
      else $error("response changed while stalled");

   // A toggle only happens on the clap that completes the sequence.
   a_toggle_needs_clap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_toggled |-> rsp_clap_accepted && (rsp_claps_so_far == '0))
      else $error("toggle without a completing clap");

   // A skipped batch neither claps nor toggles.
   a_skip_is_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_batch_skipped |-> !rsp_toggled && !rsp_clap_accepted)
      else $error("skipped batch reported activity");

   // A clap that does not toggle leaves a running sequence behind.
   a_clap_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clap_accepted && !rsp_toggled |-> (rsp_claps_so_far != '0))
      else $error("accepted clap left an empty count");

endmodule

bind triple_clap_detector tcd_checker u_tcd_checker (.*);
